/* rtl/pfx_pkg.sv */
// ----------------------------------------------------------------------------
// pfx_pkg
// shared constants, codes and types of the postfix expression evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfx_pkg;

  localparam int DATA_W      = 32;
  localparam int CH_W        = 8;
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [CH_W-1:0]   CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0]   CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0]   CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0]   CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0]   CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0]   CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0]   CH_NINE  = 8'h39;
  localparam logic [DATA_W-1:0] DEC_BASE = 32'd10;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_END
  } pfx_op_e;

  // one command from the front: optional number push, then an operation
  typedef struct packed {
    logic              push_en;
    logic [DATA_W-1:0] push_val;
    pfx_op_e           op;
  } pfx_cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PUSH,
    BK_POP_B,
    BK_GET_B,
    BK_POP_A,
    BK_GET_A,
    BK_EXEC,
    BK_DIV,
    BK_WRITE,
    BK_POP_R,
    BK_GET_R,
    BK_EMIT
  } pfx_bk_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIX
  } pfx_dv_state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } pfx_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } pfx_div_rsp_t;

  function automatic logic is_digit(logic [CH_W-1:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  function automatic pfx_op_e classify(logic [CH_W-1:0] ch);
    pfx_op_e op;
    op = OP_NONE;
    if (ch == CH_PLUS)  op = OP_ADD;
    if (ch == CH_MINUS) op = OP_SUB;
    if (ch == CH_STAR)  op = OP_MUL;
    if (ch == CH_SLASH) op = OP_DIV;
    if (ch == CH_NUL)   op = OP_END;
    return op;
  endfunction

endpackage

/* rtl/pfx_if.sv */
// ----------------------------------------------------------------------------
// pfx_in_if / pfx_out_if
// valid/ready channels for characters in and results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface pfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               overflow_flag;
  logic               underflow_flag;
  logic               div_zero_flag;

  modport source (output valid, output result_value, output overflow_flag,
                  output underflow_flag, output div_zero_flag, input ready);
  modport sink   (input valid, input result_value, input overflow_flag,
                  input underflow_flag, input div_zero_flag, output ready);
endinterface

/* rtl/pfx_front.sv */
// ----------------------------------------------------------------------------
// pfx_front
// character intake: number accumulation and token classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfx_in_if.sink            char_i,
  output logic              cmd_valid_o,
  output pfx_pkg::pfx_cmd_t cmd_o,
  input  logic              cmd_ready_i
);
  import pfx_pkg::*;

  logic [DATA_W-1:0] acc_q, acc_d;
  logic              pend_q, pend_d;
  logic              take;
  logic              digit;
  pfx_op_e           op;
  logic [CH_W-1:0]   dig_val;

  assign char_i.ready = cmd_ready_i;
  assign take         = char_i.valid && char_i.ready;
  assign digit        = is_digit(char_i.ch);
  assign op           = classify(char_i.ch);
  assign dig_val      = char_i.ch - CH_ZERO;

  // a plain separator with nothing pending sends no command
  assign cmd_valid_o    = take && !digit && (pend_q || (op != OP_NONE));
  assign cmd_o.push_en  = pend_q;
  assign cmd_o.push_val = acc_q;
  assign cmd_o.op       = op;

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    if (take) begin
      if (digit) begin
        acc_d  = acc_q * DEC_BASE + {{(DATA_W-CH_W){1'b0}}, dig_val};
        pend_d = 1'b1;
      end else begin
        acc_d  = '0;
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

endmodule

/* rtl/pfx_fifo.sv */
// ----------------------------------------------------------------------------
// pfx_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfx_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  pfx_pkg::pfx_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output pfx_pkg::pfx_cmd_t pop_data_o
);
  import pfx_pkg::*;

  pfx_cmd_t              entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign push_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* rtl/pfx_div.sv */
// ----------------------------------------------------------------------------
// pfx_div
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfx_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfx_pkg::pfx_div_req_t req_i,
  output pfx_pkg::pfx_div_rsp_t rsp_o
);
  import pfx_pkg::*;

  pfx_dv_state_e        state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 a_neg, b_neg;

  assign a_neg = req_i.dividend[DATA_W-1];
  assign b_neg = req_i.divisor[DATA_W-1];
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (req_i.start) state_d = DV_RUN;
      DV_RUN:  if (cnt_q == '0) state_d = DV_FIX;
      DV_FIX:  state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    rsp_o.done     = 1'b0;
    rsp_o.quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          quo_d = a_neg ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
          dvs_d = b_neg ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
          neg_d = a_neg ^ b_neg;
          rem_d = '0;
          cnt_d = DIV_CNT_W'(DATA_W - 1);
        end
      end
      DV_RUN: begin
        if (!diff[DATA_W]) begin
          rem_d = diff[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DATA_W-1:0];
          quo_d = {quo_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
      DV_FIX: rsp_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

endmodule

/* rtl/pfx_back.sv */
// ----------------------------------------------------------------------------
// pfx_back
// command execution: operand stack, arithmetic, divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  pfx_pkg::pfx_cmd_t cmd_i,
  pfx_out_if.source         result_o
);
  import pfx_pkg::*;

  pfx_bk_state_e     state_q, state_d;
  pfx_cmd_t          cmd_q, cmd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] a_q, a_d, b_q, b_d, res_q, res_d;
  logic              rd_ok_q, rd_ok_d;
  logic              ovf_q, ovf_d, unf_q, unf_d, dz_q, dz_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic              out_ovf_q, out_ovf_d, out_unf_q, out_unf_d, out_dz_q, out_dz_d;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [CNT_W-1:0]  cnt_m1;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;
  logic              stack_full, stack_empty;
  logic [DATA_W-1:0] prod_lo;
  logic              out_free;

  pfx_div_req_t div_req;
  pfx_div_rsp_t div_rsp;

  pfx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cnt_m1      = cnt_q - 1'b1;
  assign stack_full  = (cnt_q >= CNT_W'(STACK_DEPTH));
  assign stack_empty = (cnt_q == '0);
  assign prod_lo     = a_q * b_q;
  assign out_free    = !out_vld_q || result_o.ready;
  assign cmd_ready_o = (state_q == BK_IDLE);

  assign div_req.start    = (state_q == BK_EXEC) && (cmd_q.op == OP_DIV) && (b_q != '0);
  assign div_req.dividend = a_q;
  assign div_req.divisor  = b_q;

  assign result_o.valid          = out_vld_q;
  assign result_o.result_value   = $signed(out_val_q);
  assign result_o.overflow_flag  = out_ovf_q;
  assign result_o.underflow_flag = out_unf_q;
  assign result_o.div_zero_flag  = out_dz_q;

  function automatic pfx_bk_state_e dispatch(pfx_op_e op);
    pfx_bk_state_e s;
    unique case (op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: s = BK_POP_B;
      OP_END:                         s = BK_POP_R;
      default:                        s = BK_IDLE;
    endcase
    return s;
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (cmd_valid_i) state_d = cmd_i.push_en ? BK_PUSH : dispatch(cmd_i.op);
      BK_PUSH:  state_d = dispatch(cmd_q.op);
      BK_POP_B: state_d = BK_GET_B;
      BK_GET_B: state_d = BK_POP_A;
      BK_POP_A: state_d = BK_GET_A;
      BK_GET_A: state_d = BK_EXEC;
      BK_EXEC:  state_d = div_req.start ? BK_DIV : BK_WRITE;
      BK_DIV:   if (div_rsp.done) state_d = BK_WRITE;
      BK_WRITE: state_d = BK_IDLE;
      BK_POP_R: state_d = BK_GET_R;
      BK_GET_R: state_d = BK_EMIT;
      BK_EMIT:  if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    a_d       = a_q;
    b_d       = b_q;
    res_d     = res_q;
    rd_ok_d   = rd_ok_q;
    ovf_d     = ovf_q;
    unf_d     = unf_q;
    dz_d      = dz_q;
    out_vld_d = out_vld_q && !result_o.ready;
    out_val_d = out_val_q;
    out_ovf_d = out_ovf_q;
    out_unf_d = out_unf_q;
    out_dz_d  = out_dz_q;
    wr_en     = 1'b0;
    wr_data   = cmd_q.push_val;
    unique case (state_q) inside
      BK_IDLE: begin
        if (cmd_valid_i) cmd_d = cmd_i;
      end
      BK_PUSH, BK_WRITE: begin
        if (state_q == BK_WRITE) wr_data = res_q;
        if (stack_full) begin
          ovf_d = 1'b1;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      BK_POP_B, BK_POP_A, BK_POP_R: begin
        rd_ok_d = !stack_empty;
        if (stack_empty) unf_d = 1'b1;
        else             cnt_d = cnt_m1;
      end
      BK_GET_B: b_d   = rd_ok_q ? rd_data_q : '0;
      BK_GET_A: a_d   = rd_ok_q ? rd_data_q : '0;
      BK_GET_R: res_d = rd_ok_q ? rd_data_q : '0;
      BK_EXEC: begin
        case (cmd_q.op)
          OP_ADD:  res_d = a_q + b_q;
          OP_SUB:  res_d = a_q - b_q;
          OP_MUL:  res_d = prod_lo;
          default: begin
            // zero divisor gives zero, the divider is not started
            res_d = '0;
            if (b_q == '0) dz_d = 1'b1;
          end
        endcase
      end
      BK_DIV: begin
        if (div_rsp.done) res_d = div_rsp.quotient;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_val_d = res_q;
          out_ovf_d = ovf_q;
          out_unf_d = unf_q;
          out_dz_d  = dz_q;
          ovf_d     = 1'b0;
          unf_d     = 1'b0;
          dz_d      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      unf_q     <= 1'b0;
      dz_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      unf_q     <= unf_d;
      dz_q      <= dz_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    a_q       <= a_d;
    b_q       <= b_d;
    res_q     <= res_d;
    rd_ok_q   <= rd_ok_d;
    out_val_q <= out_val_d;
    out_ovf_q <= out_ovf_d;
    out_unf_q <= out_unf_d;
    out_dz_q  <= out_dz_d;
  end

  // operand stack, registered read of the current top entry
  always_ff @(posedge clk_i) begin
    if (wr_en) stack_mem[cnt_q[ADDR_W-1:0]] <= wr_data;
    rd_data_q <= stack_mem[cnt_m1[ADDR_W-1:0]];
  end

endmodule

/* rtl/postfix_expression_evaluator_core.sv */
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Evaluates postfix (RPN) integer expressions fed as one ASCII character per
// transaction on char_i. Digits build a 32-bit wrapping number, any other
// character first pushes a pending number; + - * / pop two operands and push
// the 32-bit wrapped result (division truncates toward zero, divide by zero
// gives 0), other characters only separate tokens, and NUL pops the result
// and sends it on result_o with sticky overflow, underflow and divide-by-zero
// flags, which are then cleared. The 128-entry operand stack keeps its
// contents between expressions. The character side takes one transaction
// per cycle while the 4-entry command queue has room. The execution side
// takes one command at a time: a number push writes the stack, +, - and *
// pop two operands through the registered memory port and write the result
// back, / also runs the one-bit-per-cycle divider, a zero divisor skips the
// divider, and NUL pops the result and waits for the result register to
// free, so a long expression runs at the pace of its operators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfx_in_if.sink    char_i,
  pfx_out_if.source result_o
);
  import pfx_pkg::*;

  // front to queue
  logic     fr_valid;
  logic     fr_ready;
  pfx_cmd_t fr_cmd;

  // queue to back
  logic     q_valid;
  logic     q_ready;
  pfx_cmd_t q_cmd;

  // intake and classification, one character per cycle while the queue has room
  pfx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd),
    .cmd_ready_i (fr_ready)
  );

  // decouples intake from the multi-cycle execution
  pfx_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // stack, arithmetic and result register
  pfx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .result_o    (result_o)
  );

`ifndef NO_ASSERTIONS
  // every accepted NUL turns into an end command
  a_nul_makes_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_i.valid && char_i.ready && (char_i.ch == CH_NUL))
      |-> (fr_valid && (fr_cmd.op == OP_END)))
    else $error("accepted NUL produced no end command");

  // digits only accumulate and never reach the queue
  a_digit_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_i.valid && char_i.ready && (char_i.ch >= CH_ZERO) && (char_i.ch <= CH_NINE))
      |-> !fr_valid)
    else $error("digit produced a command");

  // a command waiting on a busy back end stays at the queue head
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_ready) |=> (q_valid && $stable(q_cmd)))
    else $error("queue head changed while back end was busy");
`endif

endmodule

/* tb/postfix_expression_evaluator_core_test.sv */
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core_test
// Feeds postfix expression text into the evaluator one character per
// transaction and checks every result against an in-bench evaluator that
// tracks the operand stack, the number accumulator and the sticky flags.
// Directed tests cover each operator, division corners, number wrap and
// stack underflow and overflow; a random phase then sends well-formed
// expressions with random content mixed with noise, with random idling on
// both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator_core_test;
  import pfx_pkg::*;

  localparam int STALL_LIMIT   = 4000;  // cycles with no transaction at all
  localparam int RANDOM_ITEMS  = 1400;
  localparam int SETTLE_CYCLES = 200;   // a few queued divisions drain in this
  localparam int MAX_REPORTS   = 10;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     ovf;
    logic                     unf;
    logic                     dz;
  } rpn_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pfx_in_if  char_if ();
  pfx_out_if res_if ();

  postfix_expression_evaluator_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_if),
    .result_o (res_if)
  );

  // --------------------------------------------------------------------------
  // evaluator state as the block should hold it
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
  int                eval_depth    = 0;
  logic [DATA_W-1:0] eval_accum    = '0;
  bit                eval_pending  = 1'b0;
  bit                seen_ovf      = 1'b0;
  bit                seen_unf      = 1'b0;
  bit                seen_dz       = 1'b0;

  rpn_result_t pending_results [$];  // results owed by the block, oldest first

  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  int sent_cnt     = 0;
  bit idle_en      = 1'b1;

  logic [CH_W-1:0] op_chars [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  function automatic bit is_digit_char(logic [CH_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit is_token_char(logic [CH_W-1:0] c);
    return is_digit_char(c) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH || c == CH_NUL;
  endfunction

  // a push onto a full stack is lost but remembered in the overflow flag
  function automatic void stack_push(logic [DATA_W-1:0] v);
    if (eval_depth < STACK_DEPTH) begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end else begin
      seen_ovf = 1'b1;
    end
  endfunction

  // popping an empty stack yields zero and sets the underflow flag
  function automatic logic [DATA_W-1:0] stack_pop();
    if (eval_depth > 0) begin
      eval_depth--;
      return eval_stack[eval_depth];
    end
    seen_unf = 1'b1;
    return '0;
  endfunction

  // signed division truncating toward zero; min / -1 wraps back to min
  function automatic logic [DATA_W-1:0] trunc_quotient(logic [DATA_W-1:0] a,
                                                       logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] mag_a, mag_b, q;
    if (b == '0) begin
      seen_dz = 1'b1;
      return '0;
    end
    mag_a = a[DATA_W-1] ? ('0 - a) : a;
    mag_b = b[DATA_W-1] ? ('0 - b) : b;
    q     = mag_a / mag_b;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? ('0 - q) : q;
  endfunction

  // advance the evaluator by one accepted character
  function automatic void eval_char(logic [CH_W-1:0] c);
    logic [DATA_W-1:0] a, b, r;
    rpn_result_t res;
    if (is_digit_char(c)) begin
      eval_accum   = eval_accum * DEC_BASE + DATA_W'(c - CH_ZERO);
      eval_pending = 1'b1;
      return;
    end
    // any non-digit closes a number in progress
    if (eval_pending) begin
      stack_push(eval_accum);
      eval_accum   = '0;
      eval_pending = 1'b0;
    end
    case (c) inside
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
        b = stack_pop();
        a = stack_pop();
        case (c)
          CH_PLUS:  r = a + b;
          CH_MINUS: r = a - b;
          CH_STAR:  r = a * b;
          default:  r = trunc_quotient(a, b);
        endcase
        stack_push(r);
      end
      CH_NUL: begin
        res.value = stack_pop();
        res.ovf   = seen_ovf;
        res.unf   = seen_unf;
        res.dz    = seen_dz;
        pending_results.push_back(res);
        seen_ovf = 1'b0;
        seen_unf = 1'b0;
        seen_dz  = 1'b0;
      end
      default: ;  // separator
    endcase
  endfunction

  function automatic void report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every result transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rpn_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected",
                                  res_if.result_value));
      end else begin
        want = pending_results.pop_front();
        if (res_if.result_value !== want.value || res_if.overflow_flag !== want.ovf ||
            res_if.underflow_flag !== want.unf || res_if.div_zero_flag !== want.dz) begin
          report_mismatch($sformatf(
            "expected value %0d ovf %0b unf %0b dz %0b, got value %0d ovf %0b unf %0b dz %0b",
            want.value, want.ovf, want.unf, want.dz, res_if.result_value,
            res_if.overflow_flag, res_if.underflow_flag, res_if.div_zero_flag));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends a run where no transaction moves on either side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // result side back pressure: random low bursts, steady high at the end
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      // occasionally a long stretch with no stall at all
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(30, 80)) @(posedge clk_i);
      else repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // character side
  // --------------------------------------------------------------------------

  // one character transaction; valid stays up for a back-to-back next one
  task automatic send_char(input logic [CH_W-1:0] c);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.ch    <= c;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    eval_char(c);
    sent_cnt++;
  endtask

  // expression text followed by the terminating NUL
  task automatic send_expr(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // hold the character side until every owed result has come back
  task automatic wait_results_drained();
    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic logic [CH_W-1:0] random_separator();
    logic [CH_W-1:0] c;
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_COMMA;
      2:       return CH_TAB;
      default: begin
        do c = CH_W'($urandom_range(1, 255)); while (is_token_char(c));
        return c;
      end
    endcase
  endfunction

  // mostly short numbers so divisions give useful quotients, a few that wrap
  task automatic send_number();
    int n_digits;
    int r;
    r = $urandom_range(0, 19);
    if (r < 12)      n_digits = $urandom_range(1, 2);
    else if (r < 17) n_digits = $urandom_range(3, 6);
    else if (r < 19) n_digits = $urandom_range(7, 10);
    else             n_digits = $urandom_range(11, 14);
    repeat (n_digits) send_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
  endtask

  // well-formed postfix expression with random operands and operators
  task automatic send_random_expression();
    int n_operands, pushed, depth;
    bit need_sep;
    n_operands = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    pushed   = 0;
    depth    = 0;
    need_sep = 1'b0;
    while (pushed < n_operands || depth > 1) begin
      if (pushed < n_operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        if (need_sep || $urandom_range(0, 5) == 0) send_char(random_separator());
        send_number();
        pushed++;
        depth++;
        need_sep = 1'b1;
      end else begin
        if ($urandom_range(0, 2) == 0) send_char(random_separator());
        send_char(op_chars[$urandom_range(0, 3)]);
        depth--;
        need_sep = 1'b0;
      end
    end
    if ($urandom_range(0, 3) == 0) send_char(random_separator());
    send_char(CH_NUL);
  endtask

  // broken sequences: stray digits, operators, any byte and early NULs
  task automatic send_noise();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 3))
        0:       send_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
        1:       send_char(op_chars[$urandom_range(0, 3)]);
        2:       send_char(CH_W'($urandom_range(0, 255)));
        default: send_char(CH_NUL);
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  task automatic test_arith_ops();
    send_expr("3 4+");
    send_expr("10 3-");
    send_expr("6 7*");
    send_expr("84 4/");
    send_expr("2 3 4*+");
    send_expr("5,1\t2+-");
    // separator with the top bit set, number closed directly by an operator
    send_char(CH_ZERO + 8'd1);
    send_char(CH_ZERO + 8'd2);
    send_char(8'hFF);
    send_char(CH_ZERO + 8'd3);
    send_char(CH_STAR);
    send_char(CH_NUL);
  endtask

  task automatic test_division_corners();
    send_expr("7 0/");                   // zero divisor
    send_expr("0 7-2/");                 // negative dividend
    send_expr("7 0 2-/");                // negative divisor
    send_expr("0 7- 0 2-/");             // both negative
    send_expr("0 2147483648- 0 1-/");    // most negative by minus one
    send_expr("1 2/");
    send_expr("4294967295 4294967295/");
  endtask

  task automatic test_number_wrap();
    send_expr("4294967295");
    send_expr("4294967296");
    send_expr("99999999999");
    send_expr("65536 65536*");
    send_expr("2147483647 1+");
  endtask

  task automatic test_stack_underflow();
    send_char(CH_NUL);                   // result from an empty stack
    send_expr("7-");
    send_expr("+");
    send_expr("3/");
    send_expr("1 0/+");                  // underflow and zero divisor together
  endtask

  task automatic test_stack_overflow();
    // one push more than the stack holds, then fold the rest back down
    repeat (STACK_DEPTH + 1) begin
      send_char(CH_NINE);
      send_char(CH_SPACE);
    end
    send_char(CH_NUL);
    repeat (STACK_DEPTH - 2) send_char(CH_PLUS);
    send_char(CH_NUL);
  endtask

  task automatic test_random_expressions();
    int start_cnt;
    bit paused;
    start_cnt = sent_cnt;
    paused    = 1'b0;
    while (sent_cnt - start_cnt < RANDOM_ITEMS) begin
      if (!paused && sent_cnt - start_cnt >= RANDOM_ITEMS / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
      if (sent_cnt - start_cnt >= RANDOM_ITEMS * 9 / 10) idle_en = 1'b0;
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_random_expression();
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    char_if.valid <= 1'b0;
    char_if.ch    <= CH_NUL;
    rst_ni        <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_arith_ops();
    test_division_corners();
    test_number_wrap();
    test_stack_underflow();
    test_stack_overflow();
    test_random_expressions();

    // let the last results come back, then give queued work time to finish
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
